[rtl/mpsm_pkg.sv]
`default_nettype none
package mpsm_pkg;

    localparam int NODES_DEF        = 256;
    localparam int MAX_PATTERNS_DEF = 64;
    localparam int ALPHABET_DEF     = 256;

    // request codes
    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_PAT_BYTE = 3'd1;
    localparam logic [2:0] OP_PAT_END  = 3'd2;
    localparam logic [2:0] OP_BUILD    = 3'd3;
    localparam logic [2:0] OP_TEXT     = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTBUILT = 3'd3;
    localparam logic [2:0] ST_TOOMANY  = 3'd4;

    localparam logic [7:0] BYTE_LOW_INIT = 8'hFF;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_CLEAR,
        DP_SWEEP,
        DP_FIN_NOP,
        DP_FIN_ERR,
        DP_INS_IGN,
        DP_INS_RD,
        DP_INS_EVAL,
        DP_END_RD,
        DP_END_EVAL,
        DP_BLD_START,
        DP_BLD_CRD,
        DP_BLD_CCHK,
        DP_BLD_FRD,
        DP_BLD_FCHK,
        DP_BLD_WCHK,
        DP_BLD_NEXTB,
        DP_BLD_POP,
        DP_BLD_UGET,
        DP_BLD_FGET,
        DP_BLD_DONE,
        DP_TXT_NB,
        DP_TXT_OUT,
        DP_TXT_START,
        DP_TXT_RD,
        DP_TXT_CHK,
        DP_TXT_MARK
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       error;
        logic       built;
        logic       byte_ok;
        logic       in_range;
        logic       child_zero;
        logic       u_zero;
        logic       f_zero;
        logic       n_zero;
        logic       low_gt_high;
        logic       b_at_high;
        logic       q_empty;
        logic       sweep_last;
    } dp_stat_t;

endpackage
`default_nettype wire

[rtl/multi_pattern_string_matcher.sv]
// steps: a text byte reads and checks the child table once per failure link followed, then marks
// on an edge; out of range, not linked, spare codes and lock-out end at dispatch; pattern byte and end evaluate
// throughput: one request at a time, set by the walk through the child table
// build: each (node, byte in range) pair gets a child read and check; each child also walks failure links
// clear and reset: a sweep over every child table address zeroes the tables, busy meanwhile
// results appear on done for exactly one cycle; the receiver cannot stall
`default_nettype none
module multi_pattern_string_matcher #(
    parameter int NODES        = mpsm_pkg::NODES_DEF,
    parameter int MAX_PATTERNS = mpsm_pkg::MAX_PATTERNS_DEF,
    parameter int ALPHABET     = mpsm_pkg::ALPHABET_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] op,
    input  wire logic [7:0] byte_value,
    input  wire logic       last,
    output logic            done,
    output logic [6:0]      pattern_number,
    output logic [2:0]      status
);
    import mpsm_pkg::*;

    // command from the sequencer, status back from the trie datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: request dispatch, table sweep, build and search walks
    mpsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // datapath: child table, failure and output links, bfs queue
    mpsm_dp #(
        .NODES        (NODES),
        .MAX_PATTERNS (MAX_PATTERNS),
        .ALPHABET     (ALPHABET)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op_in          (op),
        .byte_in        (byte_value),
        .last_in        (last),
        .pattern_number (pattern_number),
        .status         (status)
    );

`ifndef SYNTHESIS
    // a result is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request always makes the sequencer busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // a reported match always carries ok status
    a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (pattern_number != 7'd0)) |-> (status == ST_OK))
        else $error("match reported with error status");
`endif

endmodule
`default_nettype wire

[rtl/mpsm_ram.sv]
`default_nettype none
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/mpsm_ctrl.sv]
`default_nettype none
module mpsm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    output mpsm_pkg::dp_cmd_t       cmd,
    input  wire mpsm_pkg::dp_stat_t stat
);
    import mpsm_pkg::*;

    typedef enum logic [4:0] {
        S_SWEEP_INIT,
        S_SWEEP_OP,
        S_IDLE,
        S_DISPATCH,
        S_INS_EVAL,
        S_END_EVAL,
        S_B_CRD,
        S_B_CCHK,
        S_B_FRD,
        S_B_FCHK,
        S_B_WCHK,
        S_B_NEXTB,
        S_B_POP,
        S_B_UGET,
        S_B_FGET,
        S_T_RD,
        S_T_CHK,
        S_T_MARK
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = DP_NOP;
        case (state_reg)
            S_SWEEP_INIT:
            begin
                cmd = DP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP_OP:
            begin
                cmd = DP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = DP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op == OP_CLEAR)
                begin
                    cmd        = DP_CLEAR;
                    state_next = S_SWEEP_OP;
                end
                else if (stat.op > OP_TEXT)
                begin
                    cmd        = DP_FIN_NOP;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else if (stat.error)
                begin
                    cmd        = DP_FIN_ERR;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    case (stat.op)
                        OP_PAT_BYTE:
                        begin
                            if (stat.byte_ok)
                            begin
                                cmd        = DP_INS_RD;
                                state_next = S_INS_EVAL;
                            end
                            else
                            begin
                                cmd        = DP_INS_IGN;
                                state_next = S_IDLE;
                                done_next  = 1'b1;
                            end
                        end
                        OP_PAT_END:
                        begin
                            cmd        = DP_END_RD;
                            state_next = S_END_EVAL;
                        end
                        OP_BUILD:
                        begin
                            cmd        = DP_BLD_START;
                            state_next = stat.low_gt_high ? S_B_POP : S_B_CRD;
                        end
                        OP_TEXT:
                        begin
                            if (!stat.built)
                            begin
                                cmd        = DP_TXT_NB;
                                state_next = S_IDLE;
                                done_next  = 1'b1;
                            end
                            else if (!stat.in_range)
                            begin
                                cmd        = DP_TXT_OUT;
                                state_next = S_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                cmd        = DP_TXT_START;
                                state_next = S_T_RD;
                            end
                        end
                        default:
                        begin
                            cmd        = DP_FIN_NOP;
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_EVAL:
            begin
                cmd        = DP_INS_EVAL;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_END_EVAL:
            begin
                cmd        = DP_END_EVAL;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_B_CRD:
            begin
                cmd        = DP_BLD_CRD;
                state_next = S_B_CCHK;
            end
            S_B_CCHK:
            begin
                cmd = DP_BLD_CCHK;
                if (stat.child_zero || stat.u_zero)
                begin
                    state_next = S_B_NEXTB;
                end
                else
                begin
                    state_next = S_B_FRD;
                end
            end
            S_B_FRD:
            begin
                cmd        = DP_BLD_FRD;
                state_next = S_B_FCHK;
            end
            S_B_FCHK:
            begin
                cmd = DP_BLD_FCHK;
                if (!stat.f_zero && stat.child_zero)
                begin
                    state_next = S_B_FRD;
                end
                else if (stat.child_zero)
                begin
                    state_next = S_B_NEXTB;
                end
                else
                begin
                    state_next = S_B_WCHK;
                end
            end
            S_B_WCHK:
            begin
                cmd        = DP_BLD_WCHK;
                state_next = S_B_NEXTB;
            end
            S_B_NEXTB:
            begin
                if (stat.b_at_high)
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    cmd        = DP_BLD_NEXTB;
                    state_next = S_B_CRD;
                end
            end
            S_B_POP:
            begin
                if (stat.q_empty)
                begin
                    cmd        = DP_BLD_DONE;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    cmd        = DP_BLD_POP;
                    state_next = S_B_UGET;
                end
            end
            S_B_UGET:
            begin
                cmd        = DP_BLD_UGET;
                state_next = S_B_FGET;
            end
            S_B_FGET:
            begin
                cmd        = DP_BLD_FGET;
                state_next = S_B_CRD;
            end
            S_T_RD:
            begin
                cmd        = DP_TXT_RD;
                state_next = S_T_CHK;
            end
            S_T_CHK:
            begin
                cmd = DP_TXT_CHK;
                if (!stat.n_zero && stat.child_zero)
                begin
                    state_next = S_T_RD;
                end
                else if (stat.child_zero)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_T_MARK;
                end
            end
            S_T_MARK:
            begin
                cmd        = DP_TXT_MARK;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

[rtl/mpsm_dp.sv]
`default_nettype none
module mpsm_dp #(
    parameter int NODES        = 256,
    parameter int MAX_PATTERNS = 64,
    parameter int ALPHABET     = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mpsm_pkg::dp_cmd_t cmd,
    output mpsm_pkg::dp_stat_t     stat,
    input  wire logic [2:0]        op_in,
    input  wire logic [7:0]        byte_in,
    input  wire logic              last_in,
    output logic [6:0]             pattern_number,
    output logic [2:0]             status
);
    import mpsm_pkg::*;

    localparam int NW     = $clog2(NODES);
    localparam int AW     = $clog2(ALPHABET);
    localparam int PW     = $clog2(MAX_PATTERNS + 1);
    localparam int CAW    = NW + AW;
    localparam int NDEPTH = 1 << NW;
    localparam int CDEPTH = 1 << CAW;

    // latched request
    logic [2:0]     op_reg;
    logic [7:0]     b_reg;
    logic           last_reg;
    // trie state
    logic [NW:0]    node_count_reg;
    logic [PW-1:0]  pat_count_reg;
    logic [NW-1:0]  insert_reg;
    logic [NW-1:0]  search_reg;
    logic [7:0]     low_reg;
    logic [7:0]     high_reg;
    logic           error_reg;
    logic           built_reg;
    logic [CAW-1:0] sweep_reg;
    // working registers
    logic [NW-1:0]  u_reg, fu_reg, f_reg, v_reg, w_reg, n_reg;
    logic [NW-1:0]  head_reg, tail_reg;
    logic [7:0]     bi_reg;
    logic [PW-1:0]  res_num_reg;
    logic [2:0]     res_st_reg;

    logic           c_we;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [NW-1:0]  c_wdata, c_rdata;
    logic           f_we;
    logic [NW-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
    logic           pm_we;
    logic [NW-1:0]  pm_waddr, pm_raddr;
    logic [PW-1:0]  pm_wdata, pm_rdata;
    logic           om_we;
    logic [NW-1:0]  om_waddr, om_raddr;
    logic [PW-1:0]  om_wdata, om_rdata;
    logic           q_we;
    logic [NW-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

    logic           full;
    logic           too_many;
    logic           byte_ok;
    logic           child_zero;
    logic           hop;
    logic [PW-1:0]  mark;

    function automatic logic [CAW-1:0] caddr(input logic [NW-1:0] nd, input logic [7:0] by);
        caddr = {nd, by[AW-1:0]};
    endfunction

    assign full       = (node_count_reg >= (NW+1)'(NODES));
    assign too_many   = (pat_count_reg >= PW'(MAX_PATTERNS));
    assign byte_ok    = ({1'b0, b_reg} < 9'(ALPHABET));
    assign child_zero = (c_rdata == '0);
    assign mark       = (pm_rdata != '0) ? pm_rdata : om_rdata;
    // follow a failure link: not at root and no edge on this byte
    assign hop        = (cmd == DP_TXT_CHK) ? ((n_reg != '0) && child_zero)
                                            : ((f_reg != '0) && child_zero);

    always_comb
    begin
        stat.op          = op_reg;
        stat.error       = error_reg;
        stat.built       = built_reg;
        stat.byte_ok     = byte_ok;
        stat.in_range    = byte_ok && (b_reg >= low_reg) && (b_reg <= high_reg);
        stat.child_zero  = child_zero;
        stat.u_zero      = (u_reg == '0);
        stat.f_zero      = (f_reg == '0);
        stat.n_zero      = (n_reg == '0);
        stat.low_gt_high = (low_reg > high_reg);
        stat.b_at_high   = (bi_reg == high_reg);
        stat.q_empty     = (head_reg == tail_reg);
        stat.sweep_last  = &sweep_reg;
    end

    // memory ports
    always_comb
    begin
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0; pm_raddr = '0;
        om_we = 1'b0; om_waddr = '0; om_wdata = '0; om_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        case (cmd)
            DP_SWEEP:
            begin
                c_we     = 1'b1;
                c_waddr  = sweep_reg;
                f_we     = 1'b1;
                f_waddr  = sweep_reg[NW-1:0];
                pm_we    = 1'b1;
                pm_waddr = sweep_reg[NW-1:0];
                om_we    = 1'b1;
                om_waddr = sweep_reg[NW-1:0];
            end
            DP_INS_RD:
            begin
                c_raddr = caddr(insert_reg, b_reg);
            end
            DP_INS_EVAL:
            begin
                if (child_zero && !full)
                begin
                    c_we    = 1'b1;
                    c_waddr = caddr(insert_reg, b_reg);
                    c_wdata = node_count_reg[NW-1:0];
                end
            end
            DP_END_RD:
            begin
                pm_raddr = insert_reg;
            end
            DP_END_EVAL:
            begin
                if (!too_many && (pm_rdata == '0))
                begin
                    pm_we    = 1'b1;
                    pm_waddr = insert_reg;
                    pm_wdata = pat_count_reg + PW'(1);
                end
            end
            DP_BLD_START:
            begin
                f_we  = 1'b1;
                om_we = 1'b1;
            end
            DP_BLD_CRD:
            begin
                c_raddr = caddr(u_reg, bi_reg);
            end
            DP_BLD_CCHK:
            begin
                if (!child_zero && (u_reg == '0))
                begin
                    f_we    = 1'b1;
                    f_waddr = c_rdata;
                    om_we   = 1'b1;
                    om_waddr = c_rdata;
                    q_we    = 1'b1;
                    q_waddr = tail_reg;
                    q_wdata = c_rdata;
                end
            end
            DP_BLD_FRD:
            begin
                c_raddr = caddr(f_reg, bi_reg);
                f_raddr = f_reg;
            end
            DP_BLD_FCHK:
            begin
                if (!hop)
                begin
                    if (child_zero)
                    begin
                        f_we     = 1'b1;
                        f_waddr  = v_reg;
                        om_we    = 1'b1;
                        om_waddr = v_reg;
                        q_we     = 1'b1;
                        q_waddr  = tail_reg;
                        q_wdata  = v_reg;
                    end
                    else
                    begin
                        pm_raddr = c_rdata;
                        om_raddr = c_rdata;
                    end
                end
            end
            DP_BLD_WCHK:
            begin
                f_we     = 1'b1;
                f_waddr  = v_reg;
                f_wdata  = w_reg;
                om_we    = 1'b1;
                om_waddr = v_reg;
                om_wdata = mark;
                q_we     = 1'b1;
                q_waddr  = tail_reg;
                q_wdata  = v_reg;
            end
            DP_BLD_POP:
            begin
                q_raddr = head_reg;
            end
            DP_BLD_UGET:
            begin
                f_raddr = q_rdata;
            end
            DP_TXT_RD:
            begin
                c_raddr = caddr(n_reg, b_reg);
                f_raddr = n_reg;
            end
            DP_TXT_CHK:
            begin
                if (!hop && !child_zero)
                begin
                    pm_raddr = c_rdata;
                    om_raddr = c_rdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    // trie and search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= (NW+1)'(1);
            pat_count_reg  <= '0;
            insert_reg     <= '0;
            search_reg     <= '0;
            low_reg        <= BYTE_LOW_INIT;
            high_reg       <= '0;
            error_reg      <= 1'b0;
            built_reg      <= 1'b0;
            sweep_reg      <= '0;
        end
        else
        begin
            case (cmd)
                DP_CLEAR:
                begin
                    node_count_reg <= (NW+1)'(1);
                    pat_count_reg  <= '0;
                    insert_reg     <= '0;
                    search_reg     <= '0;
                    low_reg        <= BYTE_LOW_INIT;
                    high_reg       <= '0;
                    error_reg      <= 1'b0;
                    built_reg      <= 1'b0;
                    sweep_reg      <= '0;
                end
                DP_SWEEP:
                begin
                    sweep_reg <= sweep_reg + CAW'(1);
                end
                DP_FIN_ERR:
                begin
                    if ((op_reg == OP_TEXT) && last_reg)
                    begin
                        search_reg <= '0;
                    end
                end
                DP_INS_IGN, DP_INS_RD, DP_END_RD:
                begin
                    built_reg  <= 1'b0;
                    search_reg <= '0;
                end
                DP_INS_EVAL:
                begin
                    if (child_zero && full)
                    begin
                        error_reg <= 1'b1;
                    end
                    else
                    begin
                        if (child_zero)
                        begin
                            insert_reg     <= node_count_reg[NW-1:0];
                            node_count_reg <= node_count_reg + (NW+1)'(1);
                        end
                        else
                        begin
                            insert_reg <= c_rdata;
                        end
                        if (b_reg < low_reg)
                        begin
                            low_reg <= b_reg;
                        end
                        if (b_reg > high_reg)
                        begin
                            high_reg <= b_reg;
                        end
                    end
                end
                DP_END_EVAL:
                begin
                    if (too_many || (pm_rdata != '0))
                    begin
                        error_reg <= 1'b1;
                    end
                    else
                    begin
                        pat_count_reg <= pat_count_reg + PW'(1);
                    end
                    insert_reg <= '0;
                end
                DP_BLD_DONE:
                begin
                    built_reg  <= 1'b1;
                    search_reg <= '0;
                end
                DP_TXT_NB:
                begin
                    if (last_reg)
                    begin
                        search_reg <= '0;
                    end
                end
                DP_TXT_OUT:
                begin
                    search_reg <= '0;
                end
                DP_TXT_CHK:
                begin
                    if (!hop && child_zero)
                    begin
                        search_reg <= '0;
                    end
                end
                DP_TXT_MARK:
                begin
                    search_reg <= (last_reg || (mark != '0)) ? '0 : n_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers and result
    always_ff @(posedge clk)
    begin
        case (cmd)
            DP_LATCH:
            begin
                op_reg   <= op_in;
                b_reg    <= byte_in;
                last_reg <= last_in;
            end
            DP_CLEAR, DP_FIN_NOP, DP_INS_IGN, DP_BLD_DONE, DP_TXT_OUT:
            begin
                res_num_reg <= '0;
                res_st_reg  <= ST_OK;
            end
            DP_FIN_ERR, DP_TXT_NB:
            begin
                res_num_reg <= '0;
                res_st_reg  <= ST_NOTBUILT;
            end
            DP_INS_EVAL:
            begin
                res_num_reg <= '0;
                res_st_reg  <= (child_zero && full) ? ST_FULL : ST_OK;
            end
            DP_END_EVAL:
            begin
                res_num_reg <= '0;
                if (too_many)
                begin
                    res_st_reg <= ST_TOOMANY;
                end
                else if (pm_rdata != '0)
                begin
                    res_st_reg <= ST_DUP;
                end
                else
                begin
                    res_st_reg <= ST_OK;
                end
            end
            DP_BLD_START:
            begin
                u_reg    <= '0;
                head_reg <= '0;
                tail_reg <= '0;
                bi_reg   <= low_reg;
            end
            DP_BLD_CCHK:
            begin
                v_reg <= c_rdata;
                f_reg <= fu_reg;
                if (!child_zero && (u_reg == '0))
                begin
                    tail_reg <= tail_reg + NW'(1);
                end
            end
            DP_BLD_FCHK:
            begin
                if (hop)
                begin
                    f_reg <= f_rdata;
                end
                else if (child_zero)
                begin
                    tail_reg <= tail_reg + NW'(1);
                end
                else
                begin
                    w_reg <= c_rdata;
                end
            end
            DP_BLD_WCHK:
            begin
                tail_reg <= tail_reg + NW'(1);
            end
            DP_BLD_NEXTB:
            begin
                bi_reg <= bi_reg + 8'd1;
            end
            DP_BLD_POP:
            begin
                head_reg <= head_reg + NW'(1);
            end
            DP_BLD_UGET:
            begin
                u_reg <= q_rdata;
            end
            DP_BLD_FGET:
            begin
                fu_reg <= f_rdata;
                bi_reg <= low_reg;
            end
            DP_TXT_START:
            begin
                n_reg <= search_reg;
            end
            DP_TXT_CHK:
            begin
                if (hop)
                begin
                    n_reg <= f_rdata;
                end
                else if (child_zero)
                begin
                    res_num_reg <= '0;
                    res_st_reg  <= ST_OK;
                end
                else
                begin
                    n_reg <= c_rdata;
                end
            end
            DP_TXT_MARK:
            begin
                res_num_reg <= mark;
                res_st_reg  <= ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    assign pattern_number = 7'(res_num_reg);
    assign status         = res_st_reg;

    mpsm_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(NDEPTH)) u_fail (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    mpsm_ram #(.WIDTH(PW), .DEPTH(NDEPTH)) u_pmark (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata)
    );

    mpsm_ram #(.WIDTH(PW), .DEPTH(NDEPTH)) u_omark (
        .clk(clk), .we(om_we), .waddr(om_waddr), .wdata(om_wdata),
        .raddr(om_raddr), .rdata(om_rdata)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(NDEPTH)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mpsm_pkg::*;

    // spare request codes, answered with ok and no effect
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int TRIE_NODES = NODES_DEF;
    localparam int MAX_PATS   = MAX_PATTERNS_DEF;
    localparam int ALPHA      = ALPHABET_DEF;

    // aho-corasick predictor with the queue of expected answers
    class match_scoreboard;
        bit [7:0] child [TRIE_NODES * ALPHA];
        bit [7:0] fail_to [TRIE_NODES];
        bit [6:0] pat_id [TRIE_NODES];
        bit [6:0] suffix_id [TRIE_NODES];
        int       node_cnt;
        int       pat_cnt;
        int       ins_at;
        int       walk_at;
        int       byte_lo;
        int       byte_hi;
        bit       locked;
        bit       links_ready;
        bit [6:0] want_num [$];
        bit [2:0] want_status [$];
        int       mismatches;

        function void wipe();
            foreach (child[i]) child[i] = '0;
            foreach (fail_to[i])
            begin
                fail_to[i]   = '0;
                pat_id[i]    = '0;
                suffix_id[i] = '0;
            end
            node_cnt    = 1;
            pat_cnt     = 0;
            ins_at      = 0;
            walk_at     = 0;
            byte_lo     = BYTE_LOW_INIT;
            byte_hi     = 0;
            locked      = 0;
            links_ready = 0;
        endfunction

        function void link_trie();
            int order [$];
            int u;
            int v;
            int f;
            int w;
            int hops;
            fail_to[0]   = '0;
            suffix_id[0] = '0;
            for (int b = 0; b < ALPHA; b++)
            begin
                v = child[b];
                if (v != 0)
                begin
                    fail_to[v]   = '0;
                    suffix_id[v] = '0;
                    order.push_back(v);
                end
            end
            while (order.size() != 0)
            begin
                u = order.pop_front();
                for (int b = 0; b < ALPHA; b++)
                begin
                    v = child[u * ALPHA + b];
                    if (v != 0)
                    begin
                        f = fail_to[u];
                        hops = 0;
                        while (f != 0 && child[f * ALPHA + b] == 0 && hops < TRIE_NODES)
                        begin
                            f = fail_to[f];
                            hops++;
                        end
                        w = child[f * ALPHA + b];
                        fail_to[v] = w[7:0];
                        if (w == 0)
                            suffix_id[v] = '0;
                        else
                            suffix_id[v] = (pat_id[w] != 0) ? pat_id[w] : suffix_id[w];
                        order.push_back(v);
                    end
                end
            end
            links_ready = 1;
        endfunction

        // work out the answer to one accepted request
        function void note(logic [2:0] opc, logic [7:0] bv, logic lst);
            bit [6:0] num;
            bit [2:0] st;
            int       v;
            int       n;
            int       hops;
            num = '0;
            st  = ST_OK;
            if (opc == OP_CLEAR)
                wipe();
            else if (opc >= OP_SPARE_FIRST)
                ;
            else if (locked)
            begin
                st = ST_NOTBUILT;
                if (opc == OP_TEXT && lst)
                    walk_at = 0;
            end
            else if (opc == OP_PAT_BYTE)
            begin
                links_ready = 0;
                walk_at = 0;
                v = child[ins_at * ALPHA + bv];
                if (v == 0)
                begin
                    if (node_cnt >= TRIE_NODES)
                    begin
                        locked = 1;
                        st = ST_FULL;
                    end
                    else
                    begin
                        v = node_cnt++;
                        child[ins_at * ALPHA + bv] = v[7:0];
                    end
                end
                if (!locked)
                begin
                    ins_at = v;
                    if (bv < byte_lo) byte_lo = bv;
                    if (bv > byte_hi) byte_hi = bv;
                end
            end
            else if (opc == OP_PAT_END)
            begin
                links_ready = 0;
                walk_at = 0;
                if (pat_cnt >= MAX_PATS)
                begin
                    locked = 1;
                    st = ST_TOOMANY;
                end
                else if (pat_id[ins_at] != 0)
                begin
                    locked = 1;
                    st = ST_DUP;
                end
                else
                begin
                    pat_cnt++;
                    pat_id[ins_at] = pat_cnt[6:0];
                end
                ins_at = 0;
            end
            else if (opc == OP_BUILD)
            begin
                link_trie();
                walk_at = 0;
            end
            else if (!links_ready)
            begin
                st = ST_NOTBUILT;
                if (lst)
                    walk_at = 0;
            end
            else
            begin
                n = walk_at;
                if (bv < byte_lo || bv > byte_hi)
                    n = 0;
                else
                begin
                    hops = 0;
                    while (n != 0 && child[n * ALPHA + bv] == 0 && hops < TRIE_NODES)
                    begin
                        n = fail_to[n];
                        hops++;
                    end
                    n = child[n * ALPHA + bv];
                    if (n != 0)
                    begin
                        num = (pat_id[n] != 0) ? pat_id[n] : suffix_id[n];
                        if (num != 0)
                            n = 0;
                    end
                end
                walk_at = lst ? 0 : n;
            end
            want_num.push_back(num);
            want_status.push_back(st);
        endfunction

        function void check(logic [6:0] num, logic [2:0] st);
            bit [6:0] e_num;
            bit [2:0] e_st;
            if (want_num.size() == 0)
            begin
                $error("answer with no request outstanding: pattern_number %0d status %0d",
                       num, st);
                mismatches++;
                return;
            end
            e_num = want_num.pop_front();
            e_st  = want_status.pop_front();
            if (num !== e_num)
            begin
                $error("pattern_number expected %0d actual %0d", e_num, num);
                mismatches++;
            end
            if (st !== e_st)
            begin
                $error("status expected %0d actual %0d", e_st, st);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] op = OP_CLEAR;
    logic [7:0] byte_value = '0;
    logic       last = 1'b0;
    logic       done;
    logic [6:0] pattern_number;
    logic [2:0] status;

    match_scoreboard sb = new();
    bit gaps_on = 1'b1;

    multi_pattern_string_matcher u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .byte_value     (byte_value),
        .last           (last),
        .done           (done),
        .pattern_number (pattern_number),
        .status         (status)
    );

    always #5 clk = ~clk;

    // answers are strobed for one cycle and cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(pattern_number, status);
    end

    // one request: optional idle burst, then hold start until busy is low at an edge
    task automatic send_req(input logic [2:0] o, input logic [7:0] bv, input logic l);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        op         <= o;
        byte_value <= bv;
        last       <= l;
        do @(posedge clk); while (busy);
        sb.note(o, bv, l);
    endtask

    // random pattern over a band of byte values starting at base
    task automatic add_pattern(input int len, input int base, input int w);
        for (int i = 0; i < len; i++)
            send_req(OP_PAT_BYTE, 8'(base + $urandom_range(0, w - 1)), 1'b0);
        send_req(OP_PAT_END, 8'($urandom), 1'b0);
    endtask

    task automatic text_byte(input int base, input int w);
        int r;
        logic [7:0] bv;
        r = $urandom_range(0, 19);
        if (r < 15)
            bv = 8'(base + $urandom_range(0, w - 1));
        else if (r < 17)
            bv = ($urandom_range(0, 1) != 0) ? 8'(base - 1) : 8'(base + w);
        else
            bv = 8'($urandom);
        send_req(OP_TEXT, bv, $urandom_range(0, 9) == 0);
    endtask

    // a phase of ordinary use: two rounds of loading, linking and scanning
    task automatic usage_phase();
        int base;
        int w;
        int np;
        int ntext;
        send_req(OP_CLEAR, 8'($urandom), 1'b0);
        repeat (2)
        begin
            base = $urandom_range(0, 250);
            w    = $urandom_range(2, 5);
            np   = $urandom_range(3, 8);
            for (int p = 0; p < np; p++)
            begin
                if ($urandom_range(0, 11) == 0)
                    add_pattern(0, base, w);
                else if ($urandom_range(0, 7) == 0)
                    add_pattern(1, base, w);
                else
                    add_pattern($urandom_range(3, 6), base, w);
            end
            send_req(OP_BUILD, 8'($urandom), 1'b0);
            ntext = $urandom_range(60, 90);
            for (int t = 0; t < ntext; t++)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_req(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                             8'($urandom), 1'($urandom));
                else if ($urandom_range(0, 79) == 0)
                begin
                    // stray pattern byte unlinks the trie, one text byte sees that
                    send_req(OP_PAT_BYTE, 8'(base + $urandom_range(0, w - 1)), 1'b0);
                    text_byte(base, w);
                    send_req(OP_BUILD, 8'($urandom), 1'b0);
                end
                else
                    text_byte(base, w);
            end
        end
    endtask

    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int d;
        sb.mismatches = 0;
        sb.wipe();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: text before linking, spare codes, extreme bytes, empty pattern,
        // suffix reporting, duplicate lock-out and its release by clear
        send_req(OP_TEXT, 8'h41, 1'b1);
        send_req(OP_SPARE_FIRST, 8'hFF, 1'b1);
        send_req(3'd6, 8'h00, 1'b0);
        send_req(OP_SPARE_LAST, 8'h5A, 1'b0);
        send_req(OP_PAT_BYTE, 8'h00, 1'b0);
        send_req(OP_PAT_BYTE, 8'hFF, 1'b0);
        send_req(OP_PAT_END, 8'h00, 1'b0);
        send_req(OP_PAT_BYTE, 8'hFF, 1'b0);
        send_req(OP_PAT_END, 8'h00, 1'b0);
        send_req(OP_PAT_END, 8'h00, 1'b0);
        send_req(OP_BUILD, 8'h00, 1'b0);
        send_req(OP_TEXT, 8'h00, 1'b0);
        send_req(OP_TEXT, 8'hFF, 1'b0);
        send_req(OP_TEXT, 8'hFF, 1'b0);
        send_req(OP_TEXT, 8'h80, 1'b0);
        send_req(OP_TEXT, 8'h00, 1'b1);
        send_req(OP_TEXT, 8'hFF, 1'b1);
        send_req(OP_PAT_END, 8'h00, 1'b0);
        send_req(OP_TEXT, 8'h00, 1'b1);
        send_req(OP_PAT_BYTE, 8'h7F, 1'b0);
        send_req(OP_BUILD, 8'h00, 1'b0);
        send_req(OP_CLEAR, 8'h00, 1'b0);

        // full pattern table: 64 three-byte patterns, scan, then one too many
        for (int i = 0; i < MAX_PATS; i++)
        begin
            d = i;
            for (int k = 0; k < 3; k++)
            begin
                send_req(OP_PAT_BYTE, 8'(8'h61 + d % 4), 1'b0);
                d = d / 4;
            end
            send_req(OP_PAT_END, 8'h00, 1'b0);
        end
        send_req(OP_BUILD, 8'h00, 1'b0);
        repeat (60) text_byte(8'h61, 4);
        add_pattern(4, 8'h61, 4);
        send_req(OP_TEXT, 8'h61, 1'b1);
        send_req(OP_CLEAR, 8'h00, 1'b0);

        // node store overflow with long patterns over the whole byte range
        repeat (8) add_pattern(40, 0, 256);
        send_req(OP_BUILD, 8'h00, 1'b0);
        send_req(OP_TEXT, 8'h10, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            gaps_on = (ph < 5);
            usage_phase();
        end

        @(negedge clk);
        start <= 1'b0;
        while (sb.want_num.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
